>>> design/rcpn_pkg.sv
`timescale 1ns / 1ps

package rcpn_pkg;

	// channel and field geometry
	localparam int CHANNELS = 9;
	localparam int CH_W = 4;
	localparam int W_W = 16;
	localparam int Z_W = 14;
	localparam int FRAC = 14;
	localparam int NORM_W = 16;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration port
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_HALF_MS = 2'd0;
	localparam logic [Z_W-1:0] HALF_MS_RESET = 14'd327;

	// divider geometry: quotient has one integer bit and FRAC fraction bits
	localparam int D_W = Z_W + 1;
	localparam int MAG_W = W_W;
	localparam int REM_W = MAG_W + 1;
	localparam int Q_W = FRAC + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	// spike threshold: half of full scale
	localparam int DIFF_W = NORM_W + 1;
	localparam logic signed [DIFF_W-1:0] HALF_SCALE = DIFF_W'(1 << (FRAC - 1));

	typedef struct packed {
		logic signed [NORM_W-1:0] prev;
		logic signed [NORM_W-1:0] held;
	} st_entry_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] mag;
		logic [D_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic           busy;
		logic [Q_W-1:0] quot;
	} div_stat_t;

endpackage

>>> design/rcpn_if.sv
`timescale 1ns / 1ps

interface rcpn_in_if;
	import rcpn_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel;
	logic [W_W-1:0]  pulse_width;

	modport source (output valid, channel, pulse_width, input ready);
	modport sink (input valid, channel, pulse_width, output ready);
endinterface

interface rcpn_out_if;
	import rcpn_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          out_channel;
	logic                     in_range;
	logic                     accepted;
	logic signed [NORM_W-1:0] normalized;
	logic signed [NORM_W-1:0] held_value;

	modport source (output valid, out_channel, in_range, accepted, normalized, held_value,
		input ready);
	modport sink (input valid, out_channel, in_range, accepted, normalized, held_value,
		output ready);
endinterface

>>> design/rc_pulse_normalize_spike_reject.sv
`timescale 1ns / 1ps

// rc pulse normalizer with spike rejection
// in_ch carries one measured pulse per transfer: a channel index and a width in timer
// counts. out_ch returns exactly one result per input transfer, in order: the channel,
// an in-range flag, an accepted flag, the normalized value (signed q1.14) and the
// channel's held value after this pulse.
// the apb port holds half_ms_counts (z) at byte address 0; pready is always high.
// write it only while no pulse is in flight.
// one pulse is worked on at a time. an in-range pulse passes through the 15-step
// restoring divider that forms (width - 3z) / 2z; an out-of-range pulse or channel
// does not start the divider.
// per-channel previous sample and held value live in a small synchronous ram with
// a registered read; each item reads its entry, and an in-range item then writes it
// back once. items never overlap, so the write always lands before the next read.
// the result waits in an output register: in_ch is ready again while it is unclaimed,
// and a finished item waits in its final step while out_ch is stalled.
// reset clears the ram valid bits (all entries read as zero), the sequencer, the
// output valid and sets z to 327.
module rc_pulse_normalize_spike_reject (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcpn_pkg::APB_AW-1:0] paddr,
	input  logic [rcpn_pkg::APB_DW-1:0] pwdata,
	output logic [rcpn_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	rcpn_in_if.sink                     in_ch,
	rcpn_out_if.source                  out_ch
);
	import rcpn_pkg::*;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]      state_q;
	logic [Z_W-1:0]  half_ms_counts;

	// captured item
	logic [CH_W-1:0] ch_q;
	logic [W_W-1:0]  w_q;
	logic [Z_W-1:0]  z_q;
	logic            inr_q;
	logic            neg_q;

	// range check and numerator
	logic            ch_ok;
	logic [Z_W+2:0]  five_z;
	logic [Z_W+2:0]  three_z;
	logic [W_W+1:0]  num;
	logic [W_W+1:0]  num_abs;
	logic            inr;

	div_req_t        div_req;
	div_stat_t       div_stat;
	st_entry_t       rd_data;
	st_entry_t       wr_data;
	logic            rd_en;
	logic            wr_en;
	logic [IDX_W-1:0] idx;

	// final combine
	logic signed [NORM_W-1:0] t_val;
	logic signed [DIFF_W-1:0] diff;
	logic                     acc;
	logic                     out_free;
	logic                     load_out;

	// output register
	logic                     out_valid_q;
	logic [CH_W-1:0]          out_channel_q;
	logic                     in_range_q;
	logic                     accepted_q;
	logic signed [NORM_W-1:0] normalized_q;
	logic signed [NORM_W-1:0] held_value_q;

	rcpn_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.half_ms_counts (half_ms_counts)
	);

	assign in_ch.ready = (state_q == ST_IDLE);

	// bounds z and 5z are both inclusive; zero scale rejects everything
	assign ch_ok = ch_q < CH_W'(CHANNELS);
	assign five_z = {1'b0, z_q, 2'b00} + {3'b000, z_q};
	assign three_z = {2'b00, z_q, 1'b0} + {3'b000, z_q};
	assign inr = ch_ok && (z_q != '0) && (w_q >= W_W'(z_q)) &&
		({1'b0, w_q} <= five_z);
	assign num = {2'b00, w_q} - {{(W_W+2-(Z_W+3)){1'b0}}, three_z};
	assign num_abs = num[W_W+1] ? -num : num;

	// channel index is only used for the ram when it names a real channel
	assign idx = ch_ok ? ch_q[IDX_W-1:0] : '0;

	assign div_req.start = (state_q == ST_CHECK) && inr;
	assign div_req.mag = num_abs[MAG_W-1:0];
	assign div_req.divisor = {z_q, 1'b0};

	rcpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	assign rd_en = (state_q == ST_CHECK);

	rcpn_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx),
		.wr_data (wr_data)
	);

	// quotient is at most 1.0, so it fits the signed field after the sign is applied
	assign t_val = neg_q ? -NORM_W'(div_stat.quot) : NORM_W'(div_stat.quot);
	assign diff = DIFF_W'(rd_data.prev) - DIFF_W'(t_val);
	// spike test: strictly within half scale of the previous sample
	assign acc = (diff < HALF_SCALE) && (diff > -HALF_SCALE);

	assign out_free = !out_valid_q || out_ch.ready;
	assign load_out = (state_q == ST_DONE) && out_free;

	// previous sample always follows an in-range pulse, held only when accepted
	assign wr_en = load_out && inr_q;
	assign wr_data.prev = t_val;
	assign wr_data.held = acc ? t_val : rd_data.held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!inr_q || !div_stat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			ch_q <= in_ch.channel;
			w_q <= in_ch.pulse_width;
			z_q <= half_ms_counts;
		end
		if (state_q == ST_CHECK) begin
			inr_q <= inr;
			neg_q <= num[W_W+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_channel_q <= ch_q;
			in_range_q <= inr_q;
			accepted_q <= inr_q && acc;
			normalized_q <= inr_q ? t_val : '0;
			if (!ch_ok) begin
				held_value_q <= '0;
			end else if (inr_q && acc) begin
				held_value_q <= t_val;
			end else begin
				held_value_q <= rd_data.held;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_channel = out_channel_q;
	assign out_ch.in_range = in_range_q;
	assign out_ch.accepted = accepted_q;
	assign out_ch.normalized = normalized_q;
	assign out_ch.held_value = held_value_q;
endmodule

>>> design/rcpn_cfg.sv
`timescale 1ns / 1ps

module rcpn_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcpn_pkg::APB_AW-1:0]  paddr,
	input  logic [rcpn_pkg::APB_DW-1:0]  pwdata,
	output logic [rcpn_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output logic [rcpn_pkg::Z_W-1:0]     half_ms_counts
);
	import rcpn_pkg::*;

	logic [Z_W-1:0] half_ms_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ms_q <= HALF_MS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_HALF_MS) begin
			half_ms_q <= pwdata[Z_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_HALF_MS) begin
			prdata = {{(APB_DW-Z_W){1'b0}}, half_ms_q};
		end
	end

	assign half_ms_counts = half_ms_q;
endmodule

>>> design/rcpn_div.sv
`timescale 1ns / 1ps

module rcpn_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rcpn_pkg::div_req_t  req,
	output rcpn_pkg::div_stat_t stat
);
	import rcpn_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [Q_W-1:0]   quot_q;
	logic [D_W-1:0]   d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] d_ext;
	logic             ge;

	// first step takes the integer bit, later steps shift in a zero
	assign trial = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign d_ext = {{(REM_W-D_W){1'b0}}, d_q};
	assign ge = trial >= d_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {{(REM_W-MAG_W){1'b0}}, req.mag};
			d_q <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - d_ext : trial;
			quot_q <= {quot_q[Q_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.quot = quot_q;
endmodule

>>> design/rcpn_state_mem.sv
`timescale 1ns / 1ps

module rcpn_state_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [rcpn_pkg::IDX_W-1:0] rd_addr,
	output rcpn_pkg::st_entry_t       rd_data,
	input  logic                      wr_en,
	input  logic [rcpn_pkg::IDX_W-1:0] wr_addr,
	input  rcpn_pkg::st_entry_t       wr_data
);
	import rcpn_pkg::*;

	st_entry_t           mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	st_entry_t           rd_q;
	logic                rd_vld_q;

	// per-entry valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else if (rd_en) begin
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

>>> design/rcpn_checker.sv
`timescale 1ns / 1ps

module rcpn_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [rcpn_pkg::CH_W-1:0]          out_channel,
	input logic                               in_range,
	input logic                               accepted,
	input logic signed [rcpn_pkg::NORM_W-1:0] normalized,
	input logic signed [rcpn_pkg::NORM_W-1:0] held_value
);
	import rcpn_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normalized) &&
		$stable(held_value) && $stable(out_channel))
		else $error("result changed while stalled");

	a_acc_inr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> in_range)
		else $error("accepted without in range");

	a_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> normalized == '0)
		else $error("nonzero value for out-of-range pulse");

	a_acc_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> held_value == normalized)
		else $error("accepted pulse not held");

	a_inr_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> out_channel < CH_W'(CHANNELS))
		else $error("in range on a missing channel");
endmodule

bind rc_pulse_normalize_spike_reject rcpn_checker u_rcpn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_channel (out_ch.out_channel),
	.in_range    (out_ch.in_range),
	.accepted    (out_ch.accepted),
	.normalized  (out_ch.normalized),
	.held_value  (out_ch.held_value)
);

>>> test/rcpn_result_check.sv
`timescale 1ns / 1ps

module rcpn_result_check
	import rcpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	rcpn_in_if                in_ch,
	rcpn_out_if               out_ch,
	output int                mismatches,
	output int                pending,
	output int                n_pulses,
	output int                n_in_range,
	output int                n_taken
);

	typedef struct packed {
		logic [CH_W-1:0]          ch;
		logic                     in_range;
		logic                     accepted;
		logic signed [NORM_W-1:0] norm;
		logic signed [NORM_W-1:0] held;
	} pulse_result_t;

	logic [Z_W-1:0]           scale;
	logic signed [NORM_W-1:0] prev_sample [CHANNELS];
	logic signed [NORM_W-1:0] held_sample [CHANNELS];
	pulse_result_t            expected_results [$];

	// (w - 3z) / 2z in q1.14, truncated toward zero, then the spike filter
	function automatic pulse_result_t predict_pulse(input logic [CH_W-1:0] ch,
		input logic [W_W-1:0] w);
		pulse_result_t r;
		longint z;
		longint num;
		longint mag;
		longint q;
		int t;
		int d;
		r = '0;
		r.ch = ch;
		z = longint'(scale);
		if (ch < CHANNELS) begin
			r.held = held_sample[ch];
			if (z != 0 && longint'(w) >= z && longint'(w) <= 5 * z) begin
				num = longint'(w) - 3 * z;
				mag = (num < 0) ? -num : num;
				q = (mag << FRAC) / (2 * z);
				t = (num < 0) ? -int'(q) : int'(q);
				d = int'(prev_sample[ch]) - t;
				r.in_range = 1'b1;
				r.norm = NORM_W'(t);
				if (d < (1 << (FRAC - 1)) && -d < (1 << (FRAC - 1))) begin
					held_sample[ch] = NORM_W'(t);
					r.accepted = 1'b1;
				end
				prev_sample[ch] = NORM_W'(t);
				r.held = held_sample[ch];
			end
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string what);
		if (mismatches < 10)
			$display("[%0t] %s", $time, what);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pulse_result_t got;
		pulse_result_t want;
		if (!arst_n) begin
			scale = HALF_MS_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				prev_sample[i] = '0;
				held_sample[i] = '0;
			end
			expected_results.delete();
			mismatches = 0;
			pending = 0;
			n_pulses = 0;
			n_in_range = 0;
			n_taken = 0;
		end else begin
			if (psel && penable && pready && paddr == ADDR_HALF_MS) begin
				if (pwrite)
					scale = pwdata[Z_W-1:0];
				else if (prdata !== APB_DW'(scale))
					note_mismatch($sformatf("scale readback: expected %0d got %0d",
						scale, prdata));
			end
			if (in_ch.valid && in_ch.ready) begin
				want = predict_pulse(in_ch.channel, in_ch.pulse_width);
				expected_results.push_back(want);
				n_pulses++;
				if (want.in_range)
					n_in_range++;
				if (want.accepted)
					n_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got.ch = out_ch.out_channel;
				got.in_range = out_ch.in_range;
				got.accepted = out_ch.accepted;
				got.norm = out_ch.normalized;
				got.held = out_ch.held_value;
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result ch=%0d norm=%0d held=%0d",
						got.ch, got.norm, got.held));
				end else begin
					want = expected_results.pop_front();
					if (got.ch !== want.ch || got.in_range !== want.in_range ||
						got.accepted !== want.accepted || got.norm !== want.norm ||
						got.held !== want.held)
						note_mismatch($sformatf({"result: expected ch=%0d rng=%0b acc=%0b ",
							"norm=%0d held=%0d, got ch=%0d rng=%0b acc=%0b norm=%0d held=%0d"},
							want.ch, want.in_range, want.accepted, want.norm, want.held,
							got.ch, got.in_range, got.accepted, got.norm, got.held));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> test/rc_pulse_normalize_spike_reject_test.sv
`timescale 1ns / 1ps

module rc_pulse_normalize_spike_reject_test;
	import rcpn_pkg::*;

	// cycles with no transfer and no register access before giving up
	localparam int IDLE_LIMIT = 2000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatches;
	int pending;
	int n_pulses;
	int n_in_range;
	int n_taken;

	// scale the block currently holds, mirrored here to aim the stimulus
	int cur_scale;
	int n_settings;
	int last_width [CHANNELS];
	int burst_left;
	int idle_cycles;

	// receiver stall pattern state
	int stall_left;
	int stall_mode;
	int stall_tick;

	rcpn_in_if  in_ch ();
	rcpn_out_if out_ch ();

	rc_pulse_normalize_spike_reject u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	rcpn_result_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.n_pulses   (n_pulses),
		.n_in_range (n_in_range),
		.n_taken    (n_taken)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver: segments of always-ready, hard stall, coin flip and a fixed rhythm
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(1, 40);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'b0;
			2: out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= (stall_tick % 3 != 0);
		endcase
	end

	// watchdog: any transfer or register access counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without progress", IDLE_LIMIT);
			$display("rc_pulse_normalize_spike_reject: mismatch");
			$finish;
		end
	end

	// apb access: setup cycle, then access cycle until pready
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one pulse transfer; valid stays up inside a burst, bursts are split by gaps
	task automatic push_pulse(input logic [CH_W-1:0] ch, input logic [W_W-1:0] w);
		int gap;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.channel <= ch;
		in_ch.pulse_width <= w;
		do @(posedge clk); while (!in_ch.ready);
		if (ch < CHANNELS)
			last_width[ch] = w;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(0, 24);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid after the last pulse of a phase
	task automatic release_input();
		if (in_ch.valid) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
	endtask

	// wait until every result is back and the ram write-back is done
	task automatic wait_idle();
		release_input();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int clamp_width(input int w);
		if (w < 0)
			return 0;
		if (w > 65535)
			return 65535;
		return w;
	endfunction

	// random pulse aimed at the current scale: mostly in-range values and walks
	// around the last width so the spike filter sees both sides of its threshold
	task automatic pick_pulse(output logic [CH_W-1:0] ch, output logic [W_W-1:0] w);
		int kind;
		int z;
		int hi;
		int c;
		z = cur_scale;
		hi = clamp_width(5 * z);
		kind = $urandom_range(0, 99);
		c = $urandom_range(0, CHANNELS - 1);
		ch = CH_W'(c);
		if (z == 0 || kind >= 94) begin
			// anything at all, all channel codes
			ch = CH_W'($urandom_range(0, 15));
			w = W_W'($urandom);
		end else if (kind < 45) begin
			w = W_W'($urandom_range(z, hi));
		end else if (kind < 70) begin
			// small step from last width: a step of z is exactly half scale
			w = W_W'(clamp_width(last_width[c] + $urandom_range(0, 2 * z) - z));
		end else if (kind < 78) begin
			case ($urandom_range(0, 7))
				0: w = W_W'(z - 1);
				1: w = W_W'(z);
				2: w = W_W'(hi);
				3: w = W_W'(clamp_width(5 * z + 1));
				4: w = W_W'(clamp_width(3 * z));
				5: w = W_W'(clamp_width(2 * z));
				6: w = W_W'(clamp_width(4 * z));
				default: w = W_W'(clamp_width(4 * z - 1));
			endcase
		end else if (kind < 88) begin
			// out of range, below z or above 5z where that exists
			if (hi < 65535 && $urandom_range(0, 1))
				w = W_W'($urandom_range(hi + 1, 65535));
			else
				w = W_W'($urandom_range(0, z - 1));
		end else begin
			// channel beyond the last one
			ch = CH_W'($urandom_range(CHANNELS, 15));
			w = W_W'($urandom);
		end
	endtask

	// new scale written while idle and read back, then random pulses until enough of
	// them land on a real channel in range, or at scale zero until enough are sent
	task automatic run_phase(input logic [APB_DW-1:0] word, input int n_items);
		int useful;
		int sent;
		logic [CH_W-1:0] ch;
		logic [W_W-1:0] w;
		useful = 0;
		sent = 0;
		wait_idle();
		apb_access(1'b1, ADDR_HALF_MS, word);
		apb_access(1'b0, ADDR_HALF_MS, '0);
		cur_scale = int'(word[Z_W-1:0]);
		n_settings++;
		while ((cur_scale != 0 && useful < n_items) || (cur_scale == 0 && sent < n_items)) begin
			pick_pulse(ch, w);
			push_pulse(ch, w);
			sent++;
			if (ch < CHANNELS && w >= cur_scale && w <= 5 * cur_scale)
				useful++;
		end
	endtask

	initial begin
		// everything driven to a known value from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.channel = '0;
		in_ch.pulse_width = '0;
		out_ch.ready = 1'b0;
		stall_left = 0;
		stall_mode = 0;
		stall_tick = 0;
		idle_cycles = 0;
		burst_left = 0;
		n_settings = 1;
		cur_scale = int'(HALF_MS_RESET);
		for (int i = 0; i < CHANNELS; i++)
			last_width[i] = 3 * cur_scale;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pulses at the reset scale z = 327 (3z = 981, 5z = 1635)
		apb_access(1'b0, ADDR_HALF_MS, '0);
		push_pulse(4'd0, 16'd1308);   // +0.5 exactly from zero: rejected
		push_pulse(4'd0, 16'd1307);   // just under half a step away: taken
		push_pulse(4'd0, 16'd654);    // big jump down: rejected
		push_pulse(4'd1, 16'd327);    // lower bound, full negative scale
		push_pulse(4'd1, 16'd1635);   // upper bound, full positive scale
		push_pulse(4'd1, 16'd326);    // one below the range
		push_pulse(4'd1, 16'd1636);   // one above the range
		push_pulse(4'd2, 16'd0);
		push_pulse(4'd2, 16'd65535);
		push_pulse(4'd8, 16'd981);    // last channel, centered
		push_pulse(4'd9, 16'd981);    // channels past the last are ignored
		push_pulse(4'd15, 16'd65535);
		push_pulse(4'd15, 16'd981);
		push_pulse(4'd3, 16'd982);    // tiny positive fraction
		push_pulse(4'd3, 16'd980);    // tiny negative fraction, truncated toward zero
		push_pulse(4'd4, 16'd981);
		push_pulse(4'd4, 16'd1200);
		push_pulse(4'd4, 16'd1400);
		push_pulse(4'd4, 16'd1600);
		push_pulse(4'd4, 16'd1635);
		push_pulse(4'd5, 16'd1308);   // first pulse on a fresh channel at +0.5
		push_pulse(4'd5, 16'd1307);

		// writes to unmapped addresses must leave the scale alone
		wait_idle();
		for (int a = 1; a < (1 << APB_AW); a++)
			apb_access(1'b1, APB_AW'(a), APB_DW'($urandom));
		apb_access(1'b0, ADDR_HALF_MS, '0);
		push_pulse(4'd6, 16'd1308);
		push_pulse(4'd6, 16'd981);

		// scale sweep: extremes, zero, full 14-bit, random values, back to default
		run_phase(32'd1, 70);
		run_phase({18'h3FFFF, 14'd13107}, 140);   // upper bits must be dropped
		run_phase(32'd0, 40);
		run_phase(32'd16383, 70);
		run_phase(APB_DW'($urandom_range(2, 50)), 180);
		run_phase(APB_DW'($urandom_range(51, 13106)), 180);
		run_phase(APB_DW'($urandom_range(51, 13106)), 180);
		run_phase(APB_DW'($urandom_range(2, 13106)), 180);
		run_phase(32'd327, 180);

		// drain and let the pipeline settle
		release_input();
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		$display("covered %0d pulse transfers over %0d scale settings, %0d in range",
			n_pulses, n_settings, n_in_range);
		$display("spike filter took %0d and rejected %0d in-range pulses",
			n_taken, n_in_range - n_taken);
		if (mismatches == 0 && pending == 0) begin
			$display("rc_pulse_normalize_spike_reject: match");
		end else begin
			$display("rc_pulse_normalize_spike_reject: mismatch");
		end
		$finish;
	end

endmodule

>>> files.f
design/rcpn_pkg.sv
design/rcpn_if.sv
design/rcpn_cfg.sv
design/rcpn_div.sv
design/rcpn_state_mem.sv
design/rc_pulse_normalize_spike_reject.sv
design/rcpn_checker.sv
test/rcpn_result_check.sv
test/rc_pulse_normalize_spike_reject_test.sv
